// ----- sv/lrg_pkg.sv -----
// Shared types, constants and register codes of the light ray gravity stepper.
package lrg_pkg;

  localparam int RAY_W    = 7;
  localparam int NUM_RAYS = 1 << RAY_W;
  localparam int POS_W    = 20;
  localparam int DIR_W    = 18;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W    = 20;
  localparam int ACC_W    = 24;
  localparam int ITER_W   = 64;
  localparam int FEED_W   = 52;
  localparam int ROOT_W   = 26;
  localparam int STEP_W   = 5;
  localparam int MUL_W    = 25;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
  localparam logic signed [DIR_W-1:0] DIR_ONE = 18'sd65536;

  localparam logic CMD_LAUNCH  = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_HOLE_MASS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLE_X      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLE_Y      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BEND_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_LIMIT = 3'd5;

  localparam logic [18:0] MASS_RST  = 19'd3277;
  localparam logic [15:0] GAIN_RST  = 16'd655;
  localparam logic [15:0] STEP_RST  = 16'd328;
  localparam logic [18:0] BOUND_RST = 19'd78643;

  typedef enum logic [2:0] {
    EV_LAUNCHED = 3'd0,
    EV_MOVED    = 3'd1,
    EV_CAPTURED = 3'd2,
    EV_LEFT     = 3'd3,
    EV_IGNORED  = 3'd4
  } event_e;

  typedef struct packed {
    logic                    cmd;
    logic [RAY_W-1:0]        ray;
    logic signed [POS_W-1:0] start_x;
    logic signed [POS_W-1:0] start_y;
  } in_t;

  typedef struct packed {
    logic [RAY_W-1:0]        ray_out;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    still_active;
    logic [2:0]              event_res;
  } out_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              start;
    logic              sqrt_mode;
    logic [STEP_W-1:0] steps;
    logic [ITER_W-1:0] rem;
    logic [ITER_W-1:0] den;
    logic [FEED_W-1:0] feed;
  } iter_req_t;

  typedef struct packed {
    logic              busy;
    logic [ROOT_W-1:0] q;
  } iter_rsp_t;

endpackage

// ----- sv/lrg_ram.sv -----
// Generic single write port RAM with a registered read port.
module lrg_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/lrg_iter.sv -----
// Shared bit-serial unit for restoring division and integer square root.
module lrg_iter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lrg_pkg::iter_req_t req_i,
  output lrg_pkg::iter_rsp_t rsp_o
);

  logic                            busy_q;
  logic [lrg_pkg::STEP_W-1:0]      cnt_q;
  logic                            mode_q;
  logic [lrg_pkg::ITER_W-1:0]      rem_q;
  logic [lrg_pkg::ITER_W-1:0]      den_q;
  logic [lrg_pkg::FEED_W-1:0]      feed_q;
  logic [lrg_pkg::ROOT_W-1:0]      q_q;
  logic [lrg_pkg::ITER_W-1:0]      a_w;
  logic [lrg_pkg::ITER_W-1:0]      b_w;
  logic                            ge_w;

  always_comb begin
    if (mode_q) begin
      a_w = {rem_q[lrg_pkg::ITER_W-3:0], feed_q[lrg_pkg::FEED_W-1 -: 2]};
      b_w = lrg_pkg::ITER_W'({q_q, 2'b01});
    end else begin
      a_w = {rem_q[lrg_pkg::ITER_W-2:0], feed_q[lrg_pkg::FEED_W-1]};
      b_w = den_q;
    end
    ge_w = (a_w >= b_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= req_i.steps;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == lrg_pkg::STEP_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mode_q <= req_i.sqrt_mode;
      rem_q  <= req_i.rem;
      den_q  <= req_i.den;
      feed_q <= req_i.feed;
      q_q    <= '0;
    end else if (busy_q) begin
      rem_q  <= ge_w ? (a_w - b_w) : a_w;
      q_q    <= {q_q[lrg_pkg::ROOT_W-2:0], ge_w};
      feed_q <= mode_q ? {feed_q[lrg_pkg::FEED_W-3:0], 2'b00}
                       : {feed_q[lrg_pkg::FEED_W-2:0], 1'b0};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.q    = q_q;

endmodule

// ----- sv/light_ray_gravity_step.sv -----
// Top level of the light ray marcher: ray table, sequencer and shared arithmetic.
//
// Input words (launch or advance of one ray) enter on in_valid_i/in_stall_o and
// each produces exactly one result word on out_valid_o/out_stall_i. A word is
// taken at a rising edge where valid is high and stall is low. The block works
// on one word at a time and raises in_stall_o until that word's result sits in
// the output register. A full advance is paced by the shared bit-serial unit,
// which delivers one bit per cycle for two square roots (21 and 26 bits), two
// acceleration divisions (24 bits each) and two normalising divisions (17
// bits each), next to one shared 25 by 25 bit multiplier.
// While the receiver stalls, the result word holds in the output register; the
// next input word is still accepted and worked on, and its result waits until
// the register is free. Reset clears all active flags, returns the
// configuration registers to their defaults and empties the output register.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
// must write it only while idle, which the block itself does not enforce.
module light_ray_gravity_step (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lrg_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lrg_pkg::out_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [lrg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lrg_pkg::CFG_W-1:0]     cfg_data_i
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD, ST_MDX, ST_MDY, ST_MCAP, ST_CAP, ST_SQS, ST_MDEN0, ST_MDEN1,
    ST_MDEN2, ST_AXN, ST_AXC, ST_AXD, ST_AXG, ST_AXI, ST_MN0, ST_MN1, ST_MN2,
    ST_SQL, ST_DVX, ST_DVY, ST_MV0, ST_MV1, ST_MV2, ST_WB, ST_FIN
  } state_e;

  state_e state_q;

  logic [18:0]        mass_q;
  logic signed [19:0] hole_x_q;
  logic signed [19:0] hole_y_q;
  logic [15:0]        gain_q;
  logic [15:0]        step_q;
  logic [18:0]        bound_q;

  logic [lrg_pkg::NUM_RAYS-1:0] act_q;
  logic [lrg_pkg::RAY_W-1:0]    ray_q;
  lrg_pkg::entry_t              ent_q;
  logic [20:0]                  mx_q;
  logic [20:0]                  my_q;
  logic                         negx_q;
  logic                         negy_q;
  logic [41:0]                  s_q;
  logic [20:0]                  d_q;
  logic [62:0]                  den_q;
  logic                         axis_q;
  logic [lrg_pkg::ACC_W-1:0]    acc_q;
  logic signed [25:0]           nx_q;
  logic signed [25:0]           ny_q;
  logic [50:0]                  lsq_q;
  logic [25:0]                  len_q;
  logic signed [17:0]           ndx_q;
  logic signed [17:0]           ndy_q;
  logic signed [19:0]           npx_q;
  logic signed [19:0]           npy_q;
  lrg_pkg::out_t                res_q;
  lrg_pkg::out_t                out_q;
  logic                         out_valid_q;
  logic [49:0]                  p_q;

  logic                         in_acc_w;
  logic                         ram_we;
  logic [lrg_pkg::RAY_W-1:0]    ram_waddr;
  lrg_pkg::entry_t              ram_wdata;
  logic [lrg_pkg::RAY_W-1:0]    ram_raddr;
  lrg_pkg::entry_t              ram_rdata;
  lrg_pkg::iter_req_t           iter_req;
  lrg_pkg::iter_rsp_t           iter_rsp;

  logic [lrg_pkg::MUL_W-1:0]    mul_a;
  logic [lrg_pkg::MUL_W-1:0]    mul_b;
  logic signed [20:0]           dx_w;
  logic signed [20:0]           dy_w;
  logic                         cap_hit_w;
  logic                         sat_hit_w;
  logic signed [25:0]           inc_s_w;
  logic signed [17:0]           dir_old_w;
  logic signed [25:0]           n_w;
  logic [24:0]                  nmag_x_w;
  logic [24:0]                  nmag_y_w;
  logic [16:0]                  dmag_x_w;
  logic [16:0]                  dmag_y_w;
  logic signed [17:0]           qdir_w;
  logic signed [21:0]           mv_w;
  logic signed [21:0]           pxs_w;
  logic signed [21:0]           pys_w;
  logic signed [20:0]           bnd_w;
  logic                         leave_w;
  logic                         out_free_w;

  function automatic logic signed [19:0] sat_pos(logic signed [21:0] v);
    logic signed [19:0] r;
    if (v > 22'sd524287) begin
      r = 20'sd524287;
    end else if (v < -22'sd524288) begin
      r = -20'sd524288;
    end else begin
      r = v[19:0];
    end
    return r;
  endfunction

  lrg_ram #(
    .Width(lrg_pkg::ENTRY_W),
    .Depth(lrg_pkg::NUM_RAYS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  lrg_iter u_iter (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (iter_req),
    .rsp_o (iter_rsp)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc_w    = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free_w  = !out_valid_q || !out_stall_i;

  always_comb begin
    dx_w      = {hole_x_q[19], hole_x_q} - {ram_rdata.pos_x[19], ram_rdata.pos_x};
    dy_w      = {hole_y_q[19], hole_y_q} - {ram_rdata.pos_y[19], ram_rdata.pos_y};
    cap_hit_w = (s_q < p_q[41:0]);
    sat_hit_w = (63'({p_q[39:0], 8'b0}) >= den_q);
    inc_s_w   = {2'b00, p_q[39:16]};
    dir_old_w = axis_q ? ent_q.dir_y : ent_q.dir_x;
    n_w       = {{8{dir_old_w[17]}}, dir_old_w}
              + ((axis_q ? negy_q : negx_q) ? -inc_s_w : inc_s_w);
    nmag_x_w  = nx_q[25] ? 25'(-nx_q) : 25'(nx_q);
    nmag_y_w  = ny_q[25] ? 25'(-ny_q) : 25'(ny_q);
    dmag_x_w  = ndx_q[17] ? 17'(-ndx_q) : 17'(ndx_q);
    dmag_y_w  = ndy_q[17] ? 17'(-ndy_q) : 17'(ndy_q);
    qdir_w    = {1'b0, iter_rsp.q[16:0]};
    mv_w      = {5'b0, p_q[32:16]};
    pxs_w     = {{2{ent_q.pos_x[19]}}, ent_q.pos_x};
    pys_w     = {{2{ent_q.pos_y[19]}}, ent_q.pos_y};
    bnd_w     = {2'b00, bound_q};
    leave_w   = (npx_q > bnd_w) || (npy_q > bnd_w) || (npy_q < -bnd_w);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = in_data_i.ray;
    ram_wdata = '{pos_x: in_data_i.start_x, pos_y: in_data_i.start_y,
                  dir_x: lrg_pkg::DIR_ONE, dir_y: 18'sd0};
    ram_raddr = (state_q == ST_IDLE) ? in_data_i.ray : ray_q;
    if (state_q == ST_WB) begin
      ram_we    = 1'b1;
      ram_waddr = ray_q;
      ram_wdata = '{pos_x: npx_q, pos_y: npy_q, dir_x: ndx_q, dir_y: ndy_q};
    end else if (in_acc_w && (in_data_i.cmd == lrg_pkg::CMD_LAUNCH)) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_MDX:   begin mul_a = 25'(mx_q);        mul_b = 25'(mx_q);        end
      ST_MDY:   begin mul_a = 25'(my_q);        mul_b = 25'(my_q);        end
      ST_MCAP:  begin mul_a = 25'({mass_q, 1'b0}); mul_b = 25'({mass_q, 1'b0}); end
      ST_MDEN0: begin mul_a = 25'(s_q[20:0]);   mul_b = 25'(d_q);         end
      ST_MDEN1: begin mul_a = 25'(s_q[41:21]);  mul_b = 25'(d_q);         end
      ST_AXN:   begin mul_a = 25'(mass_q);      mul_b = 25'(axis_q ? my_q : mx_q); end
      ST_AXG:   begin mul_a = 25'(gain_q);      mul_b = 25'(acc_q);       end
      ST_MN0:   begin mul_a = nmag_x_w;         mul_b = nmag_x_w;         end
      ST_MN1:   begin mul_a = nmag_y_w;         mul_b = nmag_y_w;         end
      ST_MV0:   begin mul_a = 25'(dmag_x_w);    mul_b = 25'(step_q);      end
      ST_MV1:   begin mul_a = 25'(dmag_y_w);    mul_b = 25'(step_q);      end
      default:  begin mul_a = '0;               mul_b = '0;               end
    endcase
  end

  always_comb begin
    iter_req = '0;
    unique case (state_q)
      ST_CAP: begin
        iter_req.start     = !cap_hit_w;
        iter_req.sqrt_mode = 1'b1;
        iter_req.steps     = lrg_pkg::STEP_W'(21);
        iter_req.feed      = {s_q, 10'b0};
      end
      ST_AXC: begin
        iter_req.start = (s_q != '0) && !sat_hit_w;
        iter_req.steps = lrg_pkg::STEP_W'(lrg_pkg::ACC_W);
        iter_req.rem   = 64'({p_q[39:0], 8'b0});
        iter_req.den   = 64'(den_q);
      end
      ST_MN2: begin
        iter_req.start     = 1'b1;
        iter_req.sqrt_mode = 1'b1;
        iter_req.steps     = lrg_pkg::STEP_W'(lrg_pkg::ROOT_W);
        iter_req.feed      = 52'(lsq_q) + 52'(p_q);
      end
      ST_SQL: begin
        iter_req.start = !iter_rsp.busy && (iter_rsp.q != '0);
        iter_req.steps = lrg_pkg::STEP_W'(17);
        iter_req.rem   = 64'(nmag_x_w[24:1]);
        iter_req.den   = 64'(iter_rsp.q);
        iter_req.feed  = {nmag_x_w[0], 51'b0};
      end
      ST_DVX: begin
        iter_req.start = !iter_rsp.busy;
        iter_req.steps = lrg_pkg::STEP_W'(17);
        iter_req.rem   = 64'(nmag_y_w[24:1]);
        iter_req.den   = 64'(len_q);
        iter_req.feed  = {nmag_y_w[0], 51'b0};
      end
      default: iter_req = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q   <= lrg_pkg::MASS_RST;
      hole_x_q <= '0;
      hole_y_q <= '0;
      gain_q   <= lrg_pkg::GAIN_RST;
      step_q   <= lrg_pkg::STEP_RST;
      bound_q  <= lrg_pkg::BOUND_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lrg_pkg::REG_HOLE_MASS:   mass_q   <= cfg_data_i[18:0];
        lrg_pkg::REG_HOLE_X:      hole_x_q <= cfg_data_i;
        lrg_pkg::REG_HOLE_Y:      hole_y_q <= cfg_data_i;
        lrg_pkg::REG_BEND_GAIN:   gain_q   <= cfg_data_i[15:0];
        lrg_pkg::REG_STEP_LENGTH: step_q   <= cfg_data_i[15:0];
        lrg_pkg::REG_BOUND_LIMIT: bound_q  <= cfg_data_i[18:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      act_q       <= '0;
      out_valid_q <= 1'b0;
      axis_q      <= 1'b0;
    end else begin
      if ((state_q == ST_FIN) && out_free_w) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc_w) begin
            ray_q <= in_data_i.ray;
            if (in_data_i.cmd == lrg_pkg::CMD_LAUNCH) begin
              act_q[in_data_i.ray] <= 1'b1;
              res_q <= '{ray_out: in_data_i.ray, pos_x: in_data_i.start_x,
                         pos_y: in_data_i.start_y, still_active: 1'b1,
                         event_res: lrg_pkg::EV_LAUNCHED};
              state_q <= ST_FIN;
            end else begin
              state_q <= ST_RD;
            end
          end
        end
        ST_RD: begin
          ent_q  <= ram_rdata;
          negx_q <= dx_w[20];
          negy_q <= dy_w[20];
          mx_q   <= dx_w[20] ? 21'(-dx_w) : 21'(dx_w);
          my_q   <= dy_w[20] ? 21'(-dy_w) : 21'(dy_w);
          if (!act_q[ray_q]) begin
            res_q <= '{ray_out: ray_q, pos_x: ram_rdata.pos_x, pos_y: ram_rdata.pos_y,
                       still_active: 1'b0, event_res: lrg_pkg::EV_IGNORED};
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_MDX;
          end
        end
        ST_MDX:  state_q <= ST_MDY;
        ST_MDY: begin
          s_q     <= p_q[41:0];
          state_q <= ST_MCAP;
        end
        ST_MCAP: begin
          s_q     <= s_q + p_q[41:0];
          state_q <= ST_CAP;
        end
        ST_CAP: begin
          if (cap_hit_w) begin
            act_q[ray_q] <= 1'b0;
            res_q <= '{ray_out: ray_q, pos_x: ent_q.pos_x, pos_y: ent_q.pos_y,
                       still_active: 1'b0, event_res: lrg_pkg::EV_CAPTURED};
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_SQS;
          end
        end
        ST_SQS: begin
          if (!iter_rsp.busy) begin
            d_q     <= iter_rsp.q[20:0];
            state_q <= ST_MDEN0;
          end
        end
        ST_MDEN0: state_q <= ST_MDEN1;
        ST_MDEN1: begin
          den_q   <= 63'(p_q[41:0]);
          state_q <= ST_MDEN2;
        end
        ST_MDEN2: begin
          den_q   <= den_q + 63'({p_q[41:0], 21'b0});
          axis_q  <= 1'b0;
          state_q <= ST_AXN;
        end
        ST_AXN: state_q <= ST_AXC;
        ST_AXC: begin
          priority if (s_q == '0) begin
            acc_q   <= '0;
            state_q <= ST_AXG;
          end else if (sat_hit_w) begin
            acc_q   <= lrg_pkg::ACC_MAX;
            state_q <= ST_AXG;
          end else begin
            state_q <= ST_AXD;
          end
        end
        ST_AXD: begin
          if (!iter_rsp.busy) begin
            acc_q   <= iter_rsp.q[lrg_pkg::ACC_W-1:0];
            state_q <= ST_AXG;
          end
        end
        ST_AXG: state_q <= ST_AXI;
        ST_AXI: begin
          if (!axis_q) begin
            nx_q    <= n_w;
            axis_q  <= 1'b1;
            state_q <= ST_AXN;
          end else begin
            ny_q    <= n_w;
            state_q <= ST_MN0;
          end
        end
        ST_MN0: state_q <= ST_MN1;
        ST_MN1: begin
          lsq_q   <= 51'(p_q);
          state_q <= ST_MN2;
        end
        ST_MN2: state_q <= ST_SQL;
        ST_SQL: begin
          if (!iter_rsp.busy) begin
            len_q <= iter_rsp.q;
            if (iter_rsp.q == '0) begin
              ndx_q   <= ent_q.dir_x;
              ndy_q   <= ent_q.dir_y;
              state_q <= ST_MV0;
            end else begin
              state_q <= ST_DVX;
            end
          end
        end
        ST_DVX: begin
          if (!iter_rsp.busy) begin
            ndx_q   <= nx_q[25] ? -qdir_w : qdir_w;
            state_q <= ST_DVY;
          end
        end
        ST_DVY: begin
          if (!iter_rsp.busy) begin
            ndy_q   <= ny_q[25] ? -qdir_w : qdir_w;
            state_q <= ST_MV0;
          end
        end
        ST_MV0: state_q <= ST_MV1;
        ST_MV1: begin
          npx_q   <= sat_pos(ndx_q[17] ? (pxs_w - mv_w) : (pxs_w + mv_w));
          state_q <= ST_MV2;
        end
        ST_MV2: begin
          npy_q   <= sat_pos(ndy_q[17] ? (pys_w - mv_w) : (pys_w + mv_w));
          state_q <= ST_WB;
        end
        ST_WB: begin
          res_q.ray_out <= ray_q;
          res_q.pos_x   <= npx_q;
          res_q.pos_y   <= npy_q;
          if (leave_w) begin
            act_q[ray_q]       <= 1'b0;
            res_q.still_active <= 1'b0;
            res_q.event_res    <= lrg_pkg::EV_LEFT;
          end else begin
            res_q.still_active <= 1'b1;
            res_q.event_res    <= lrg_pkg::EV_MOVED;
          end
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free_w) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_FIN) && out_free_w) begin
      out_q <= res_q;
    end
  end

  a_iter_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !iter_rsp.busy)
    else $error("iterative unit busy while the sequencer is idle");

  a_launch_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc_w && (in_data_i.cmd == lrg_pkg::CMD_LAUNCH)) |=>
      (state_q == ST_FIN) && res_q.still_active &&
      (res_q.event_res == lrg_pkg::EV_LAUNCHED))
    else $error("launch word did not go straight to the result stage");

  a_dead_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((out_data_o.event_res == lrg_pkg::EV_CAPTURED) ||
                     (out_data_o.event_res == lrg_pkg::EV_LEFT) ||
                     (out_data_o.event_res == lrg_pkg::EV_IGNORED)))
      |-> !out_data_o.still_active)
    else $error("terminal event reported with an active ray");

  a_wb_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !iter_rsp.busy)
    else $error("ray table written while the iterative unit is running");

endmodule

// ----- sim/light_ray_gravity_step_test.sv -----
// Self-checking testbench of the light ray gravity stepper, with its own predictor.
module light_ray_gravity_step_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall_o;
  lrg_pkg::in_t in_data = '0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  lrg_pkg::out_t out_data_o;
  logic cfg_we = 1'b0;
  logic [lrg_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [lrg_pkg::CFG_W-1:0] cfg_data = '0;

  light_ray_gravity_step u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall_o), .in_data_i(in_data),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor copy of the configuration and the ray table.
  longint mass = lrg_pkg::MASS_RST, hole_px = 0, hole_py = 0;
  longint gain = lrg_pkg::GAIN_RST, stride = lrg_pkg::STEP_RST;
  longint bound = lrg_pkg::BOUND_RST;
  longint ray_px [lrg_pkg::NUM_RAYS];
  longint ray_py [lrg_pkg::NUM_RAYS];
  longint ray_dx [lrg_pkg::NUM_RAYS];
  longint ray_dy [lrg_pkg::NUM_RAYS];
  bit ray_live [lrg_pkg::NUM_RAYS];

  lrg_pkg::in_t pending_words[$];
  lrg_pkg::out_t expected_words[$];
  bit launched [lrg_pkg::NUM_RAYS];
  int launched_ids[$];
  int errors = 0;
  int tx_idle = 0, rx_stall = 0;
  bit in_taken = 1'b0;
  bit hold_go = 1'b0, hold_on = 1'b0;

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint bend_inc(longint off, longint unsigned s, longint unsigned d);
    longint unsigned m = mag(off);
    bit [127:0] q;
    longint unsigned a, inc;
    if (s == 0 || m == 0 || d == 0) return 0;
    q = ({64'd0, 64'(longint'(mass) * m)} << 32) / {64'd0, s * d};
    a = (q > lrg_pkg::ACC_MAX) ? longint'(lrg_pkg::ACC_MAX) : q[63:0];
    inc = (longint'(gain) * a) >> 16;
    return off < 0 ? -longint'(inc) : longint'(inc);
  endfunction

  function automatic longint unit_scale(longint v, longint unsigned len);
    longint unsigned q = (mag(v) << 16) / len;
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint step_move(longint dir);
    longint unsigned q = (mag(dir) * longint'(stride)) >> 16;
    return dir < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp20(longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  function automatic lrg_pkg::out_t march_ray(lrg_pkg::in_t w);
    lrg_pkg::out_t o;
    int r = w.ray;
    longint dx, dy, nx, ny;
    longint unsigned s, cap, d, len;
    lrg_pkg::event_e ev = lrg_pkg::EV_IGNORED;
    if (w.cmd == lrg_pkg::CMD_LAUNCH) begin
      ray_px[r] = w.start_x;
      ray_py[r] = w.start_y;
      ray_dx[r] = lrg_pkg::DIR_ONE;
      ray_dy[r] = 0;
      ray_live[r] = 1'b1;
      ev = lrg_pkg::EV_LAUNCHED;
    end else if (ray_live[r]) begin
      dx = hole_px - ray_px[r];
      dy = hole_py - ray_py[r];
      s = mag(dx) * mag(dx) + mag(dy) * mag(dy);
      cap = 2 * mass;
      if (s < cap * cap) begin
        ray_live[r] = 1'b0;
        ev = lrg_pkg::EV_CAPTURED;
      end else begin
        d = int_root(s);
        nx = ray_dx[r] + bend_inc(dx, s, d);
        ny = ray_dy[r] + bend_inc(dy, s, d);
        len = int_root(mag(nx) * mag(nx) + mag(ny) * mag(ny));
        if (len != 0) begin
          ray_dx[r] = unit_scale(nx, len);
          ray_dy[r] = unit_scale(ny, len);
        end
        ray_px[r] = clamp20(ray_px[r] + step_move(ray_dx[r]));
        ray_py[r] = clamp20(ray_py[r] + step_move(ray_dy[r]));
        if (ray_px[r] > bound || ray_py[r] > bound || ray_py[r] < -bound) begin
          ray_live[r] = 1'b0;
          ev = lrg_pkg::EV_LEFT;
        end else begin
          ev = lrg_pkg::EV_MOVED;
        end
      end
    end
    o.ray_out = w.ray;
    o.pos_x = ray_px[r][lrg_pkg::POS_W-1:0];
    o.pos_y = ray_py[r][lrg_pkg::POS_W-1:0];
    o.still_active = ray_live[r];
    o.event_res = ev;
    return o;
  endfunction

  // Sender and receiver, both changing at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || in_taken) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= tx_idle) begin
          in_data <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= hold_on || ($urandom_range(99) < rx_stall);
    end
  end

  always @(posedge clk_i) begin
    lrg_pkg::out_t exp_w;
    if (rst_ni) begin
      in_taken = in_valid && !in_stall_o;
      if (in_taken) expected_words = {expected_words, march_ray(in_data)};
      if (out_valid_o && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("result word for ray %0d with nothing expected", out_data_o.ray_out);
          errors++;
        end else begin
          exp_w = expected_words.pop_front();
          if (out_data_o.ray_out !== exp_w.ray_out) begin
            $error("ray_out: expected %0d, got %0d", exp_w.ray_out, out_data_o.ray_out);
            errors++;
          end
          if (out_data_o.pos_x !== exp_w.pos_x) begin
            $error("pos_x: expected %0d, got %0d", exp_w.pos_x, out_data_o.pos_x);
            errors++;
          end
          if (out_data_o.pos_y !== exp_w.pos_y) begin
            $error("pos_y: expected %0d, got %0d", exp_w.pos_y, out_data_o.pos_y);
            errors++;
          end
          if (out_data_o.still_active !== exp_w.still_active) begin
            $error("still_active: expected %0d, got %0d", exp_w.still_active,
                   out_data_o.still_active);
            errors++;
          end
          if (out_data_o.event_res !== exp_w.event_res) begin
            $error("event_res: expected %0d, got %0d", exp_w.event_res,
                   out_data_o.event_res);
            errors++;
          end
        end
      end
    end
  end

  // A long hold-off of the receiver so that the block fills and stalls its input.
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_on = 1'b1;
    repeat (600) @(posedge clk_i);
    hold_on = 1'b0;
  end

  initial begin
    #30ms;
    $display("FAIL light_ray_gravity_step");
    $finish;
  end

  task automatic put_word(logic cmd, int r, longint x, longint y);
    lrg_pkg::in_t w;
    w.cmd = cmd;
    w.ray = r[lrg_pkg::RAY_W-1:0];
    w.start_x = x[lrg_pkg::POS_W-1:0];
    w.start_y = y[lrg_pkg::POS_W-1:0];
    if (cmd == lrg_pkg::CMD_LAUNCH && !launched[r]) begin
      launched[r] = 1'b1;
      launched_ids = {launched_ids, r};
    end
    pending_words = {pending_words, w};
  endtask

  task automatic write_reg(logic [lrg_pkg::CFG_IDX_W-1:0] idx, longint val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val[lrg_pkg::CFG_W-1:0];
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      lrg_pkg::REG_HOLE_MASS:   mass = val & 64'h7FFFF;
      lrg_pkg::REG_HOLE_X:      hole_px = longint'(signed'(val[lrg_pkg::POS_W-1:0]));
      lrg_pkg::REG_HOLE_Y:      hole_py = longint'(signed'(val[lrg_pkg::POS_W-1:0]));
      lrg_pkg::REG_BEND_GAIN:   gain = val & 64'hFFFF;
      lrg_pkg::REG_STEP_LENGTH: stride = val & 64'hFFFF;
      lrg_pkg::REG_BOUND_LIMIT: bound = val & 64'h7FFFF;
      default: ;
    endcase
  endtask

  task automatic set_all(longint m, longint hx, longint hy, longint g, longint s, longint b);
    write_reg(lrg_pkg::REG_HOLE_MASS, m);
    write_reg(lrg_pkg::REG_HOLE_X, hx);
    write_reg(lrg_pkg::REG_HOLE_Y, hy);
    write_reg(lrg_pkg::REG_BEND_GAIN, g);
    write_reg(lrg_pkg::REG_STEP_LENGTH, s);
    write_reg(lrg_pkg::REG_BOUND_LIMIT, b);
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic longint start_coord();
    if ($urandom_range(99) < 20) return longint'(signed'(20'($urandom)));
    return longint'($urandom_range(2 * bound)) - bound;
  endfunction

  task automatic random_words(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      if (launched_ids.size() == 0 || $urandom_range(99) < 35) begin
        r = $urandom_range(lrg_pkg::NUM_RAYS - 1);
        put_word(lrg_pkg::CMD_LAUNCH, r, start_coord(), start_coord());
      end else begin
        r = launched_ids[$urandom_range(launched_ids.size() - 1)];
        put_word(lrg_pkg::CMD_ADVANCE, r, start_coord(), start_coord());
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset configuration: corners, capture, ignored rays, and an on-axis ray.
    put_word(lrg_pkg::CMD_LAUNCH, 0, -524288, -524288);
    put_word(lrg_pkg::CMD_ADVANCE, 0, 0, 0);
    put_word(lrg_pkg::CMD_LAUNCH, 127, 524287, 524287);
    put_word(lrg_pkg::CMD_ADVANCE, 127, 0, 0);
    put_word(lrg_pkg::CMD_ADVANCE, 127, 0, 0);
    put_word(lrg_pkg::CMD_LAUNCH, 5, 0, 0);
    put_word(lrg_pkg::CMD_ADVANCE, 5, 0, 0);
    put_word(lrg_pkg::CMD_ADVANCE, 5, 0, 0);
    put_word(lrg_pkg::CMD_LAUNCH, 6, -70000, 6000);
    for (int i = 0; i < 6; i++) put_word(lrg_pkg::CMD_ADVANCE, 6, 0, 0);
    put_word(lrg_pkg::CMD_LAUNCH, 7, -30000, 0);
    for (int i = 0; i < 3; i++) put_word(lrg_pkg::CMD_ADVANCE, 7, 0, 0);
    put_word(lrg_pkg::CMD_LAUNCH, 6, 1000, -1000);
    random_words(60);
    drain();

    // The bend exactly cancels the direction, so the old direction is kept.
    tx_idle = 56;
    set_all(1024, 0, 0, 16384, 328, 78643);
    put_word(lrg_pkg::CMD_LAUNCH, 9, 4096, 0);
    put_word(lrg_pkg::CMD_ADVANCE, 9, 0, 0);
    put_word(lrg_pkg::CMD_ADVANCE, 9, 0, 0);
    random_words(300);
    drain();

    // Largest gain, step and bound, with the position saturating at the edge.
    tx_idle = 0;
    rx_stall = 56;
    set_all(0, -524288, 524287, 65535, 65535, 524287);
    put_word(lrg_pkg::CMD_LAUNCH, 11, 524000, 0);
    put_word(lrg_pkg::CMD_ADVANCE, 11, 0, 0);
    put_word(lrg_pkg::CMD_ADVANCE, 11, 0, 0);
    hold_go = 1'b1;
    random_words(150);
    drain();
    random_words(150);
    drain();

    tx_idle = 27;
    rx_stall = 27;
    set_all(524287, 524287, -524288, 0, 0, 0);
    random_words(120);
    drain();
    set_all(0, 0, 0, 0, 0, 0);
    random_words(100);
    drain();

    tx_idle = 0;
    rx_stall = 0;
    set_all($urandom_range(20000), longint'($urandom_range(131072)) - 65536,
            longint'($urandom_range(131072)) - 65536, $urandom_range(65535),
            $urandom_range(4000), $urandom_range(200000));
    random_words(300);
    drain();
    repeat (200) @(posedge clk_i);

    if (errors == 0 && expected_words.size() == 0) begin
      $display("PASS light_ray_gravity_step");
    end else begin
      $display("FAIL light_ray_gravity_step");
    end
    $finish;
  end

endmodule
